// File: rtl/vesa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vesa_pkg: shared types and constants of the encounter speed arbiter
// Request layouts, fixed-point limits, angle thresholds and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package vesa_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_BITS   = 16;

  localparam int AW    = ANGLE_BITS + 1;
  localparam int ZW    = ANGLE_BITS + 3;
  localparam int CW    = 36;
  localparam int MW    = 33;
  localparam int PW    = 58;
  localparam int CNT_W = 5;
  localparam int DIV_ITER = 14;

  localparam int HS_L = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
  localparam int HS_R = (ANGLE_BITS >= 16) ? 0 : 16 - ANGLE_BITS;

  localparam logic [ANGLE_BITS-1:0] HALF_U = ANGLE_BITS'(longint'(1) << (ANGLE_BITS - 1));
  localparam logic signed [AW-1:0] ANG_HALF = AW'(longint'(1) << (ANGLE_BITS - 1));
  localparam logic signed [ZW-1:0] Z_HALF = ZW'(longint'(1) << (ANGLE_BITS - 1));
  localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(longint'(1) << (ANGLE_BITS - 2));

  localparam logic signed [AW-1:0] ANG_2618 =
    AW'(((longint'(2618000) << ANGLE_BITS) + longint'(3141593)) / longint'(6283185));
  localparam logic signed [AW-1:0] ANG_1047 =
    AW'(((longint'(1047000) << ANGLE_BITS) + longint'(3141593)) / longint'(6283185));
  localparam logic signed [AW-1:0] ANG_525 =
    AW'(((longint'(525000) << ANGLE_BITS) + longint'(3141593)) / longint'(6283185));

  localparam logic signed [CW-1:0] GAIN_Q30 = CW'(652032874);
  localparam logic [15:0] ONE_Q14         = 16'd16384;
  localparam logic [15:0] BOOST_OVERTAKEN = 16'd19661;
  localparam logic [15:0] BOOST_CROSSING  = 16'd18842;
  localparam logic [15:0] SLOW_SPEED      = 16'd205;
  localparam logic [49:0] MIN_RANGE_SQ    = 50'd16384;
  localparam logic [49:0] NEAR_CROSS_SQ   = 50'd58982400;
  localparam logic signed [29:0] TEN_M_Q8 = 30'sd2560;
  localparam logic signed [PW-1:0] CROSS_LIMIT = PW'(longint'(6400) << 30);
  localparam logic [32:0] RECIP_TEN = 33'd52429;

  localparam logic [2:0] RULE_NONE      = 3'd0;
  localparam logic [2:0] RULE_HEAD_ON   = 3'd1;
  localparam logic [2:0] RULE_OVERTAKE  = 3'd2;
  localparam logic [2:0] RULE_GIVE_WAY  = 3'd3;
  localparam logic [2:0] RULE_STAND_ON  = 3'd4;

  localparam logic [1:0] CFG_OWN_ID     = 2'd0;
  localparam logic [1:0] CFG_ACT_RANGE  = 2'd1;
  localparam logic [1:0] CFG_GW_FLOOR   = 2'd2;

  localparam logic [31:0] ATAN_TURNS [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic signed [31:0] ego_x;
    logic signed [31:0] ego_y;
    logic signed [15:0] ego_heading;
    logic [15:0]        ego_speed;
    logic signed [31:0] nbr_x;
    logic signed [31:0] nbr_y;
    logic signed [15:0] nbr_heading;
    logic [15:0]        nbr_speed;
    logic [7:0]         nbr_tag;
    logic               present;
    logic               last_neighbor;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  rule_code;
    logic [14:0] speed_scale;
  } out_req_t;

  function automatic logic signed [AW-1:0] atan_step(input logic [CNT_W-1:0] i);
    logic [32:0] t;
    t = {1'b0, ATAN_TURNS[i]} + (33'd1 << (31 - ANGLE_BITS));
    return AW'(t >> (32 - ANGLE_BITS));
  endfunction

  function automatic logic signed [AW-1:0] wrap_ang(input logic [ANGLE_BITS-1:0] u);
    return (u > HALF_U) ? {1'b1, u} : {1'b0, u};
  endfunction

  function automatic logic signed [AW-1:0] heading_ang(input logic [15:0] raw);
    logic [39:0] t;
    t = ({24'd0, raw} << HS_L) >> HS_R;
    return wrap_ang(t[ANGLE_BITS-1:0]);
  endfunction

endpackage
`default_nettype wire

// File: rtl/vessel_encounter_speed_arbiter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vessel_encounter_speed_arbiter: encounter rule and speed factor arbiter
// Evaluates one neighbor per request against the own vessel with a shared
// CORDIC unit, a shared multiplier, a bit-serial square root and a
// bit-serial divider, and aggregates the governing rule over a set.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_ready_o  | vesa_pkg::in_req_t
//   out     | output    | out_valid_o/out_ready_i| vesa_pkg::out_req_t
//   cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// A skipped neighbor goes straight to the final state; a gated-out one leaves
// at the box or range check; a fully evaluated one runs the 26-step square
// root, three CORDIC passes and, if needed, the 14-step ramp divider.
// in_ready_o is high only while the sequencer is idle. A result waits in the
// output register; a closing request stalls only while that register is full.
// Reset clears the aggregate and loads the register defaults.
// ----------------------------------------------------------------------------
module vessel_encounter_speed_arbiter (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire vesa_pkg::in_req_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output vesa_pkg::out_req_t      out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [23:0]        cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_GATE, ST_SQX, ST_SQY, ST_SQA, ST_CHK, ST_SQRT, ST_VINIT,
    ST_VEC, ST_ANG, ST_ROT1, ST_PA1, ST_PA2, ST_PC1, ST_PC2, ST_RINIT,
    ST_ROT2, ST_NV, ST_CLASS, ST_DSET, ST_DIV, ST_SHAPE, ST_HEADF, ST_AGG,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {FK_HEAD, FK_OVER, FK_GIVE} kind_e;

  state_e state_q;
  kind_e  kind_q;

  logic [7:0]  own_id_q;
  logic [23:0] act_range_q;
  logic [14:0] gw_floor_q;

  vesa_pkg::in_req_t  in_q;
  vesa_pkg::out_req_t out_q;
  logic               out_valid_q;

  logic signed [32:0] dx_q, dy_q;
  logic [49:0] sq_q, sv_q;
  logic [51:0] root_q, bit_q;
  logic [24:0] dist_q;

  logic signed [vesa_pkg::CW-1:0] cx_q, cy_q;
  logic signed [vesa_pkg::ZW-1:0] cz_q;
  logic                           flip_q;
  logic [vesa_pkg::CNT_W-1:0]     cnt_q;

  logic signed [vesa_pkg::AW-1:0] brg_q, hdg_q, bfn_q;
  logic signed [vesa_pkg::PW-1:0] prod_q, pa_q, pc_q;

  logic signed [29:0] num_q, den_q;
  logic [25:0] rem_q;
  logic [14:0] ramp_q;
  logic [15:0] f_q;
  logic [2:0]  rule_q;

  logic [15:0] run_factor_q;
  logic        conflict_q;
  logic [2:0]  lead_rule_q;
  logic [31:0] near_range_q;

  // shared multiplier
  logic signed [vesa_pkg::MW-1:0]   mul_a, mul_b;
  logic signed [2*vesa_pkg::MW-1:0] mul_p;
  logic signed [vesa_pkg::CW-1:0]   cos_v, sin_v;
  logic [16:0] head_v;

  assign cos_v  = flip_q ? -cx_q : cx_q;
  assign sin_v  = flip_q ? -cy_q : cy_q;
  assign head_v = {2'b0, ramp_q} + {1'b0, ramp_q, 1'b0} + 17'd5;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQX:   begin mul_a = dx_q; mul_b = dx_q; end
      ST_SQY:   begin mul_a = dy_q; mul_b = dy_q; end
      ST_SQA:   begin
        mul_a = $signed({9'd0, act_range_q});
        mul_b = $signed({9'd0, act_range_q});
      end
      ST_PA1:   begin mul_a = dx_q; mul_b = vesa_pkg::MW'(cos_v); end
      ST_PA2:   begin mul_a = dy_q; mul_b = vesa_pkg::MW'(sin_v); end
      ST_PC1:   begin mul_a = dy_q; mul_b = vesa_pkg::MW'(cos_v); end
      ST_PC2:   begin mul_a = dx_q; mul_b = vesa_pkg::MW'(sin_v); end
      ST_NV:    begin
        mul_a = $signed({17'd0, in_q.nbr_speed});
        mul_b = vesa_pkg::MW'(cos_v);
      end
      ST_SHAPE: begin
        mul_a = $signed({16'd0, head_v});
        mul_b = $signed(vesa_pkg::RECIP_TEN);
      end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // shared CORDIC step
  logic                           c_dir;
  logic signed [vesa_pkg::CW-1:0] c_xs, c_ys, c_nx, c_ny;
  logic signed [vesa_pkg::ZW-1:0] c_at, c_nz;

  always_comb begin
    c_dir = (state_q == ST_VEC) ? cy_q[vesa_pkg::CW-1] : !cz_q[vesa_pkg::ZW-1];
    c_xs  = cx_q >>> cnt_q;
    c_ys  = cy_q >>> cnt_q;
    c_at  = vesa_pkg::ZW'(vesa_pkg::atan_step(cnt_q));
    if (c_dir) begin
      c_nx = cx_q - c_ys;
      c_ny = cy_q + c_xs;
      c_nz = cz_q - c_at;
    end else begin
      c_nx = cx_q + c_ys;
      c_ny = cy_q - c_xs;
      c_nz = cz_q + c_at;
    end
  end

  // angles and rotation start
  logic signed [vesa_pkg::AW-1:0] eh, nh, ang, d_brg, d_hdg, d_bfn, rot_ang;
  logic signed [vesa_pkg::ZW-1:0] rz, rz_init;
  logic                           r_flip;

  always_comb begin
    eh    = vesa_pkg::heading_ang(in_q.ego_heading);
    nh    = vesa_pkg::heading_ang(in_q.nbr_heading);
    ang   = vesa_pkg::wrap_ang(cz_q[vesa_pkg::ANGLE_BITS-1:0]);
    d_brg = ang - eh;
    d_hdg = nh - eh;
    d_bfn = ang + vesa_pkg::ANG_HALF - nh;
    rot_ang = (state_q == ST_ANG) ? eh : hdg_q;
    rz = vesa_pkg::ZW'(rot_ang);
    if (rz > vesa_pkg::Z_QUARTER) begin
      rz_init = rz - vesa_pkg::Z_HALF;
      r_flip  = 1'b1;
    end else if (rz < -vesa_pkg::Z_QUARTER) begin
      rz_init = rz + vesa_pkg::Z_HALF;
      r_flip  = 1'b1;
    end else begin
      rz_init = rz;
      r_flip  = 1'b0;
    end
  end

  // square root step
  logic [51:0] sq_rb;
  logic        sq_take;
  logic [51:0] sq_root_n;
  assign sq_rb     = root_q + bit_q;
  assign sq_take   = {2'b0, sv_q} >= sq_rb;
  assign sq_root_n = sq_take ? ((root_q >> 1) + bit_q) : (root_q >> 1);

  // divider step
  logic [26:0] div_rem2;
  logic        div_take;
  assign div_rem2 = {rem_q, 1'b0};
  assign div_take = {3'd0, div_rem2} >= 30'(den_q);

  // classification terms
  logic signed [vesa_pkg::AW-1:0] ab, ah;
  logic signed [29:0] a_s, dist_s, p_s;
  logic signed [vesa_pkg::PW-1:0] pa_shr;
  logic pc_in, closing, bfn_in;
  logic [16:0] gw_raw;
  logic [15:0] gw_f;

  always_comb begin
    ab      = brg_q[vesa_pkg::AW-1] ? -brg_q : brg_q;
    ah      = hdg_q[vesa_pkg::AW-1] ? -hdg_q : hdg_q;
    a_s     = $signed({6'd0, act_range_q});
    dist_s  = $signed({5'd0, dist_q});
    pa_shr  = pa_q >>> 30;
    p_s     = pa_shr[29:0];
    pc_in   = (pc_q > -vesa_pkg::CROSS_LIMIT) && (pc_q < vesa_pkg::CROSS_LIMIT);
    closing = prod_q > $signed(vesa_pkg::PW'({in_q.ego_speed, 30'd0}));
    bfn_in  = (bfn_q > -vesa_pkg::ANG_1047) && (bfn_q < vesa_pkg::ANG_1047);
    gw_raw  = {1'b0, vesa_pkg::ONE_Q14} - (({2'b0, ramp_q} + 17'd1) >> 1);
    gw_f    = (gw_raw[15:0] < {1'b0, gw_floor_q}) ? {1'b0, gw_floor_q} : gw_raw[15:0];
  end

  // result load
  logic out_load;
  assign out_load = (state_q == ST_FIN) && in_q.last_neighbor && (!out_valid_q || out_ready_i);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      kind_q       <= FK_HEAD;
      own_id_q     <= '0;
      act_range_q  <= 24'd12800;
      gw_floor_q   <= 15'd8192;
      in_q         <= '0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
      dx_q         <= '0;
      dy_q         <= '0;
      sq_q         <= '0;
      sv_q         <= '0;
      root_q       <= '0;
      bit_q        <= '0;
      dist_q       <= '0;
      cx_q         <= '0;
      cy_q         <= '0;
      cz_q         <= '0;
      flip_q       <= 1'b0;
      cnt_q        <= '0;
      brg_q        <= '0;
      hdg_q        <= '0;
      bfn_q        <= '0;
      prod_q       <= '0;
      pa_q         <= '0;
      pc_q         <= '0;
      num_q        <= '0;
      den_q        <= '0;
      rem_q        <= '0;
      ramp_q       <= '0;
      f_q          <= vesa_pkg::ONE_Q14;
      rule_q       <= vesa_pkg::RULE_NONE;
      run_factor_q <= vesa_pkg::ONE_Q14;
      conflict_q   <= 1'b0;
      lead_rule_q  <= vesa_pkg::RULE_NONE;
      near_range_q <= '1;
    end else begin
      prod_q <= vesa_pkg::PW'(mul_p);

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          vesa_pkg::CFG_OWN_ID:    own_id_q    <= cfg_data_i[7:0];
          vesa_pkg::CFG_ACT_RANGE: act_range_q <= cfg_data_i;
          vesa_pkg::CFG_GW_FLOOR:  gw_floor_q  <= cfg_data_i[14:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            in_q <= in_data_i;
            dx_q <= 33'(in_data_i.nbr_x) - 33'(in_data_i.ego_x);
            dy_q <= 33'(in_data_i.nbr_y) - 33'(in_data_i.ego_y);
            if (in_data_i.present && (in_data_i.nbr_tag != own_id_q)) begin
              state_q <= ST_GATE;
            end else begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_GATE: begin
          if ((dx_q > $signed({9'd0, act_range_q})) || (-dx_q > $signed({9'd0, act_range_q}))
              || (dy_q > $signed({9'd0, act_range_q}))
              || (-dy_q > $signed({9'd0, act_range_q}))) begin
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_SQX;
          end
        end
        ST_SQX: state_q <= ST_SQY;
        ST_SQY: begin
          sq_q    <= 50'(prod_q);
          state_q <= ST_SQA;
        end
        ST_SQA: begin
          sq_q    <= sq_q + 50'(prod_q);
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          if ((sq_q > 50'(prod_q)) || (sq_q < vesa_pkg::MIN_RANGE_SQ)) begin
            state_q <= ST_FIN;
          end else begin
            sv_q    <= sq_q;
            root_q  <= '0;
            bit_q   <= 52'd1 << 50;
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_take) begin
            sv_q <= sv_q - sq_rb[49:0];
          end
          root_q <= sq_root_n;
          bit_q  <= bit_q >> 2;
          if (bit_q[0]) begin
            dist_q  <= sq_root_n[24:0];
            state_q <= ST_VINIT;
          end
        end
        ST_VINIT: begin
          cnt_q <= '0;
          if (dx_q[32]) begin
            cx_q <= -(vesa_pkg::CW'(dx_q) <<< 6);
            cy_q <= -(vesa_pkg::CW'(dy_q) <<< 6);
            cz_q <= vesa_pkg::Z_HALF;
          end else begin
            cx_q <= vesa_pkg::CW'(dx_q) <<< 6;
            cy_q <= vesa_pkg::CW'(dy_q) <<< 6;
            cz_q <= '0;
          end
          state_q <= ST_VEC;
        end
        ST_VEC, ST_ROT1, ST_ROT2: begin
          cx_q  <= c_nx;
          cy_q  <= c_ny;
          cz_q  <= c_nz;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == vesa_pkg::CNT_W'(vesa_pkg::CORDIC_STEPS - 1)) begin
            priority case (state_q)
              ST_VEC:  state_q <= ST_ANG;
              ST_ROT1: state_q <= ST_PA1;
              default: state_q <= ST_NV;
            endcase
          end
        end
        ST_ANG: begin
          brg_q   <= vesa_pkg::wrap_ang(d_brg[vesa_pkg::ANGLE_BITS-1:0]);
          hdg_q   <= vesa_pkg::wrap_ang(d_hdg[vesa_pkg::ANGLE_BITS-1:0]);
          bfn_q   <= vesa_pkg::wrap_ang(d_bfn[vesa_pkg::ANGLE_BITS-1:0]);
          cx_q    <= vesa_pkg::GAIN_Q30;
          cy_q    <= '0;
          cz_q    <= rz_init;
          flip_q  <= r_flip;
          cnt_q   <= '0;
          state_q <= ST_ROT1;
        end
        ST_PA1: state_q <= ST_PA2;
        ST_PA2: begin
          pa_q    <= prod_q;
          state_q <= ST_PC1;
        end
        ST_PC1: begin
          pa_q    <= pa_q + prod_q;
          state_q <= ST_PC2;
        end
        ST_PC2: begin
          pc_q    <= prod_q;
          state_q <= ST_RINIT;
        end
        ST_RINIT: begin
          pc_q    <= pc_q - prod_q;
          cx_q    <= vesa_pkg::GAIN_Q30;
          cy_q    <= '0;
          cz_q    <= rz_init;
          flip_q  <= r_flip;
          cnt_q   <= '0;
          state_q <= ST_ROT2;
        end
        ST_NV: state_q <= ST_CLASS;
        ST_CLASS: begin
          if ((ah > vesa_pkg::ANG_2618) && (ab < vesa_pkg::ANG_1047)) begin
            rule_q  <= vesa_pkg::RULE_HEAD_ON;
            kind_q  <= FK_HEAD;
            num_q   <= a_s - dist_s;
            den_q   <= a_s;
            state_q <= ST_DSET;
          end else if ((ah < vesa_pkg::ANG_525) && pc_in) begin
            if (pa_q > 0) begin
              if (in_q.nbr_speed >= vesa_pkg::SLOW_SPEED) begin
                rule_q  <= vesa_pkg::RULE_OVERTAKE;
                kind_q  <= FK_OVER;
                num_q   <= a_s - (p_s <<< 1);
                den_q   <= a_s;
                state_q <= ST_DSET;
              end else begin
                state_q <= ST_FIN;
              end
            end else if (in_q.ego_speed >= vesa_pkg::SLOW_SPEED) begin
              rule_q  <= vesa_pkg::RULE_STAND_ON;
              f_q     <= vesa_pkg::BOOST_OVERTAKEN;
              state_q <= ST_AGG;
            end else begin
              state_q <= ST_FIN;
            end
          end else if ((ah > vesa_pkg::ANG_525) && (ah < vesa_pkg::ANG_2618)) begin
            if ((sq_q < vesa_pkg::NEAR_CROSS_SQ) && closing && bfn_in) begin
              if (brg_q > 0) begin
                rule_q <= vesa_pkg::RULE_GIVE_WAY;
                kind_q <= FK_GIVE;
                num_q  <= a_s - dist_s;
                den_q  <= a_s - vesa_pkg::TEN_M_Q8;
                if (a_s == vesa_pkg::TEN_M_Q8) begin
                  ramp_q  <= (a_s > dist_s) ? vesa_pkg::ONE_Q14[14:0] : '0;
                  state_q <= ST_SHAPE;
                end else begin
                  state_q <= ST_DSET;
                end
              end else begin
                rule_q  <= vesa_pkg::RULE_STAND_ON;
                f_q     <= vesa_pkg::BOOST_CROSSING;
                state_q <= ST_AGG;
              end
            end else begin
              state_q <= ST_FIN;
            end
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_DSET: begin
          if ((num_q <= 0) || (den_q <= 0)) begin
            ramp_q  <= '0;
            state_q <= ST_SHAPE;
          end else if (num_q >= den_q) begin
            ramp_q  <= vesa_pkg::ONE_Q14[14:0];
            state_q <= ST_SHAPE;
          end else begin
            rem_q   <= num_q[25:0];
            ramp_q  <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_take) begin
            rem_q <= 26'(30'(div_rem2) - 30'(den_q));
          end else begin
            rem_q <= div_rem2[25:0];
          end
          ramp_q <= {ramp_q[13:0], div_take};
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == vesa_pkg::CNT_W'(vesa_pkg::DIV_ITER - 1)) begin
            state_q <= ST_SHAPE;
          end
        end
        ST_SHAPE: begin
          unique case (kind_q)
            FK_HEAD: state_q <= ST_HEADF;
            FK_OVER: begin
              f_q     <= (ramp_q != '0) ? gw_f : vesa_pkg::ONE_Q14;
              state_q <= ST_AGG;
            end
            default: begin
              f_q     <= gw_f;
              state_q <= ST_AGG;
            end
          endcase
        end
        ST_HEADF: begin
          f_q     <= vesa_pkg::ONE_Q14 - 16'(prod_q >>> 19);
          state_q <= ST_AGG;
        end
        ST_AGG: begin
          if (f_q < vesa_pkg::ONE_Q14) begin
            conflict_q <= 1'b1;
            if (f_q < run_factor_q) begin
              run_factor_q <= f_q;
              lead_rule_q  <= rule_q;
            end
          end else if (!conflict_q && (f_q > vesa_pkg::ONE_Q14)
                       && ({7'd0, dist_q} < near_range_q)) begin
            run_factor_q <= f_q;
            lead_rule_q  <= rule_q;
            near_range_q <= {7'd0, dist_q};
          end
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!in_q.last_neighbor) begin
            state_q <= ST_IDLE;
          end else if (out_load) begin
            out_q.rule_code   <= lead_rule_q;
            out_q.speed_scale <= run_factor_q[14:0];
            run_factor_q <= vesa_pkg::ONE_Q14;
            conflict_q   <= 1'b0;
            lead_rule_q  <= vesa_pkg::RULE_NONE;
            near_range_q <= '1;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: verif/vessel_encounter_speed_arbiter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vessel_encounter_speed_arbiter_tb: self-checking bench for the arbiter
// Feeds neighbor sets under random idling on both channels and under register
// settings that include the extremes. Each accepted request runs through a
// bit-exact software copy of the encounter rules, and every closing request's
// verdict is compared field by field with the block's output.
// ----------------------------------------------------------------------------
module vessel_encounter_speed_arbiter_tb;

  localparam longint AFULL = longint'(1) << vesa_pkg::ANGLE_BITS;
  localparam longint AHALF = longint'(1) << (vesa_pkg::ANGLE_BITS - 1);
  localparam longint AQUART = longint'(1) << (vesa_pkg::ANGLE_BITS - 2);
  localparam longint TH_2618 =
    ((longint'(2618000) << vesa_pkg::ANGLE_BITS) + 3141593) / 6283185;
  localparam longint TH_1047 =
    ((longint'(1047000) << vesa_pkg::ANGLE_BITS) + 3141593) / 6283185;
  localparam longint TH_525 =
    ((longint'(525000) << vesa_pkg::ANGLE_BITS) + 3141593) / 6283185;
  localparam longint Q14 = 16384;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk_i, rst_ni;
  logic in_valid, in_ready;
  vesa_pkg::in_req_t in_data;
  logic out_valid, out_ready;
  vesa_pkg::out_req_t out_data;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [23:0] cfg_data;

  vessel_encounter_speed_arbiter i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // predictor state
  longint unsigned own_id_m, act_range_m, floor_m;
  longint unsigned run_factor, standon_dist;
  bit conflict_m;
  logic [2:0] lead_rule;

  vesa_pkg::in_req_t neighbor_q[$];
  vesa_pkg::out_req_t verdict_q[$];
  int errors, cycles, n_req, n_verdicts;
  bit in_taken, out_taken;
  int send_gap, recv_hold;
  bit long_hold_go, long_hold_done;

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint wrap_a(longint v);
    longint u;
    u = v & (AFULL - 1);
    return (u > AHALF) ? u - AFULL : u;
  endfunction

  function automatic longint atan_inc(int i);
    return (longint'(vesa_pkg::ATAN_TURNS[i]) + (longint'(1) << (31 - vesa_pkg::ANGLE_BITS)))
           >> (32 - vesa_pkg::ANGLE_BITS);
  endfunction

  function automatic longint hdg_of(logic [15:0] raw);
    longint u;
    u = longint'(raw);
    if (vesa_pkg::ANGLE_BITS >= 16) u = u << (vesa_pkg::ANGLE_BITS - 16);
    else u = u >> (16 - vesa_pkg::ANGLE_BITS);
    return wrap_a(u);
  endfunction

  task automatic rotate(input longint ang, output longint c, output longint s);
    longint z, x, y, nx, ny;
    bit flip;
    z = ang; x = 652032874; y = 0; flip = 0;
    if (z > AQUART) begin z -= AHALF; flip = 1; end
    else if (z < -AQUART) begin z += AHALF; flip = 1; end
    for (int i = 0; i < vesa_pkg::CORDIC_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_inc(i);
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_inc(i);
      end
      x = nx; y = ny;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint bearing_of(longint dx, longint dy);
    longint x, y, z, nx, ny;
    x = dx * 64; y = dy * 64; z = 0;
    if (x < 0) begin x = -x; y = -y; z = AHALF; end
    for (int i = 0; i < vesa_pkg::CORDIC_STEPS && i < 24; i++) begin
      if (y < 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_inc(i);
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_inc(i);
      end
      x = nx; y = ny;
    end
    return wrap_a(z);
  endfunction

  function automatic longint unsigned root_of(longint unsigned v);
    longint unsigned r, b;
    r = 0; b = longint'(1) << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin v -= r + b; r = (r >> 1) + b; end
      else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint ramp_of(longint num, longint den);
    longint q;
    if (num <= 0 || den <= 0) return 0;
    q = (num * Q14) / den;
    return (q > Q14) ? Q14 : q;
  endfunction

  function automatic longint yield_factor(longint ramp);
    longint f;
    f = Q14 - ((ramp + 1) >> 1);
    return (f < longint'(floor_m)) ? longint'(floor_m) : f;
  endfunction

  task automatic assess_encounter(input vesa_pkg::in_req_t r);
    longint a, dx, dy, rng, ang, brg, hdg, bfn, ab, ah, c, s, ch, sh, pa, pc, f, rr, den;
    longint unsigned sq;
    logic [2:0] rule;
    a = longint'(act_range_m);
    dx = longint'(r.nbr_x) - longint'(r.ego_x);
    dy = longint'(r.nbr_y) - longint'(r.ego_y);
    f = Q14; rule = vesa_pkg::RULE_NONE;
    if (dx > a || -dx > a || dy > a || -dy > a) return;
    sq = longint'(dx * dx) + longint'(dy * dy);
    if (sq > a * a || sq < 16384) return;
    rng = longint'(root_of(sq));
    ang = bearing_of(dx, dy);
    brg = wrap_a(ang - hdg_of(r.ego_heading));
    hdg = wrap_a(hdg_of(r.nbr_heading) - hdg_of(r.ego_heading));
    bfn = wrap_a(ang + AHALF - hdg_of(r.nbr_heading));
    ab = brg < 0 ? -brg : brg;
    ah = hdg < 0 ? -hdg : hdg;
    rotate(hdg_of(r.ego_heading), c, s);
    pa = dx * c + dy * s;
    pc = dy * c - dx * s;
    if (pc < 0) pc = -pc;
    rotate(hdg, ch, sh);
    if (ah > TH_2618 && ab < TH_1047) begin
      rule = vesa_pkg::RULE_HEAD_ON;
      f = Q14 - (3 * ramp_of(a - rng, a) + 5) / 10;
    end else if (ah < TH_525 && pc < (longint'(6400) << 30)) begin
      if (pa > 0) begin
        if (r.nbr_speed >= 205) begin
          rr = ramp_of(a - 2 * (pa >>> 30), a);
          rule = vesa_pkg::RULE_OVERTAKE;
          f = rr > 0 ? yield_factor(rr) : Q14;
        end
      end else if (r.ego_speed >= 205) begin
        rule = vesa_pkg::RULE_STAND_ON;
        f = 19661;
      end
    end else if (ah > TH_525 && ah < TH_2618) begin
      if (sq < 58982400 && longint'(r.nbr_speed) * ch > (longint'(r.ego_speed) << 30) &&
          bfn > -TH_1047 && bfn < TH_1047) begin
        if (brg > 0) begin
          den = a - 2560;
          if (den == 0) rr = (a - rng) > 0 ? Q14 : 0;
          else rr = ramp_of(a - rng, den);
          rule = vesa_pkg::RULE_GIVE_WAY;
          f = yield_factor(rr);
        end else begin
          rule = vesa_pkg::RULE_STAND_ON;
          f = 18842;
        end
      end
    end
    if (f < Q14) begin
      conflict_m = 1;
      if (f < longint'(run_factor)) begin run_factor = f; lead_rule = rule; end
    end else if (!conflict_m && f > Q14 && longint'(rng) < standon_dist) begin
      run_factor = f; lead_rule = rule; standon_dist = rng;
    end
  endtask

  task automatic clear_set();
    run_factor = Q14; conflict_m = 0; lead_rule = vesa_pkg::RULE_NONE;
    standon_dist = 64'hFFFFFFFF;
  endtask

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("error @%0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // monitor: predict at acceptance, check verdicts
  always @(posedge clk_i or negedge rst_ni) begin
    vesa_pkg::out_req_t w;
    if (!rst_ni) begin
      own_id_m = 0; act_range_m = 12800; floor_m = 8192; clear_set();
      in_taken = 0; out_taken = 0;
    end else begin
      in_taken = in_valid && in_ready;
      out_taken = out_valid && out_ready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          vesa_pkg::CFG_OWN_ID: own_id_m = 64'(cfg_data[7:0]);
          vesa_pkg::CFG_ACT_RANGE: act_range_m = 64'(cfg_data);
          vesa_pkg::CFG_GW_FLOOR: floor_m = 64'(cfg_data[14:0]);
          default: ;
        endcase
      end
      if (out_taken) begin
        n_verdicts++;
        if (verdict_q.size() == 0) report("unexpected verdict rule", out_data.rule_code, -1);
        else begin
          w = verdict_q.pop_front();
          if (out_data.rule_code !== w.rule_code)
            report("rule_code", out_data.rule_code, w.rule_code);
          if (out_data.speed_scale !== w.speed_scale)
            report("speed_scale", out_data.speed_scale, w.speed_scale);
        end
      end
      if (in_taken) begin
        n_req++;
        if (in_data.present && in_data.nbr_tag != own_id_m[7:0]) assess_encounter(in_data);
        if (in_data.last_neighbor) begin
          w.rule_code = lead_rule;
          w.speed_scale = run_factor[14:0];
          verdict_q.push_back(w);
          clear_set();
        end
      end
    end
  end

  // request driver
  always @(negedge clk_i) begin
    bit busy;
    if (rst_ni) begin
      busy = in_valid && !in_taken;
      if (!busy) begin
        if (send_gap > 0) send_gap--;
        else if (neighbor_q.size() > 0) begin
          in_data <= neighbor_q.pop_front();
          busy = 1;
          send_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
        end
      end
      in_valid <= busy;
    end
  end

  // verdict receiver
  always @(negedge clk_i) begin
    bit rdy;
    if (rst_ni) begin
      rdy = 1;
      if (recv_hold > 0) begin
        recv_hold--; rdy = 0;
      end else if (long_hold_go && !long_hold_done) begin
        long_hold_done = 1; recv_hold = 600; rdy = 0;
      end else if (out_taken) begin
        recv_hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
        if (recv_hold > 0) begin recv_hold--; rdy = 0; end
      end
      out_ready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic vesa_pkg::in_req_t encounter(bit present, bit last);
    vesa_pkg::in_req_t r;
    int unsigned span;
    int off_x, off_y;
    r.ego_x = $urandom; r.ego_y = $urandom;
    if ($urandom_range(0, 9) == 0) r.ego_x = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h7FFFFFF0};
    r.ego_heading = 16'($urandom);
    r.ego_speed = 16'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 300) : $urandom);
    r.nbr_speed = 16'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 300) : $urandom);
    case ($urandom_range(0, 3))
      0: r.nbr_heading = r.ego_heading + 16'h8000 + 16'($urandom_range(0, 8000)) - 16'd4000;
      1: r.nbr_heading = r.ego_heading + 16'($urandom_range(0, 8000)) - 16'd4000;
      default: r.nbr_heading = 16'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0: span = 200;
      1, 2: span = 9000;
      9: span = 32'h7FFFFFFF;
      default: span = 32'(act_range_m + act_range_m / 8);
    endcase
    off_x = int'($urandom_range(0, span)) * ($urandom_range(0, 1) ? 1 : -1);
    off_y = int'($urandom_range(0, span)) * ($urandom_range(0, 1) ? 1 : -1);
    r.nbr_x = r.ego_x + off_x;
    r.nbr_y = r.ego_y + off_y;
    r.nbr_tag = ($urandom_range(0, 7) == 0) ? own_id_m[7:0] : 8'($urandom);
    r.present = present;
    r.last_neighbor = last;
    return r;
  endfunction

  function automatic vesa_pkg::in_req_t placed(int dx, int dy, logic [15:0] eh,
                                               logic [15:0] nh, logic [15:0] ev,
                                               logic [15:0] nv, bit last);
    vesa_pkg::in_req_t r;
    r = '0;
    r.ego_heading = eh; r.nbr_heading = nh; r.ego_speed = ev; r.nbr_speed = nv;
    r.nbr_x = dx; r.nbr_y = dy; r.nbr_tag = 8'd9; r.present = 1; r.last_neighbor = last;
    return r;
  endfunction

  task automatic settle();
    while (neighbor_q.size() > 0 || verdict_q.size() > 0 || in_valid) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(negedge clk_i);
    cfg_index <= idx; cfg_data <= val; cfg_valid <= 1;
    do @(posedge clk_i); while (!(cfg_valid && cfg_ready));
    @(negedge clk_i);
    cfg_valid <= 0;
  endtask

  task automatic random_sets(int count);
    int k, n;
    k = 0;
    while (k < count) begin
      n = $urandom_range(1, 4);
      for (int j = 0; j < n; j++) begin
        neighbor_q.push_back(encounter($urandom_range(0, 9) != 0, j == n - 1));
        k++;
      end
      if ($urandom_range(0, 9) == 0) begin
        neighbor_q.push_back(encounter(0, $urandom_range(0, 1)));
        k++;
      end
    end
  endtask

  initial begin
    vesa_pkg::in_req_t r;
    rst_ni = 0; in_valid = 0; in_data = '0; out_ready = 0;
    cfg_valid = 0; cfg_index = vesa_pkg::CFG_OWN_ID; cfg_data = '0;
    errors = 0; cycles = 0; n_req = 0; n_verdicts = 0; send_gap = 0; recv_hold = 0;
    long_hold_go = 0; long_hold_done = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed encounters under reset settings
    r = '0; r.last_neighbor = 1; neighbor_q.push_back(r);
    neighbor_q.push_back(placed(0, 5000, 16'h4000, 16'hC000, 1000, 1000, 1));
    neighbor_q.push_back(placed(0, 3000, 16'h4000, 16'h4000, 300, 2000, 1));
    neighbor_q.push_back(placed(0, 3000, 16'h4000, 16'h4000, 300, 100, 1));
    neighbor_q.push_back(placed(0, -3000, 16'h4000, 16'h4000, 600, 100, 1));
    neighbor_q.push_back(placed(3000, 3000, 16'h4000, 16'h8000, 100, 3000, 0));
    neighbor_q.push_back(placed(-3000, 3000, 16'h4000, 16'h0000, 100, 3000, 1));
    neighbor_q.push_back(placed(-3000, 0, 16'h0000, 16'h4000, 100, 3000, 1));
    r = placed(0, 2000, 16'h4000, 16'hC000, 500, 500, 1); r.nbr_tag = 0;
    neighbor_q.push_back(r);
    neighbor_q.push_back(placed(100, 0, 16'h0000, 16'h8000, 500, 500, 1));
    neighbor_q.push_back(placed(12801, 0, 16'h0000, 16'h8000, 500, 500, 1));
    neighbor_q.push_back(placed(12800, 0, 16'h8000, 16'h0000, 16'hFFFF, 16'hFFFF, 1));
    r = placed(0, 0, 16'h7FFF, 16'h8000, 0, 16'hFFFF, 0);
    r.ego_x = 32'h7FFFFFFF; r.ego_y = 32'h80000000; r.nbr_x = 32'h80000000;
    r.nbr_y = 32'h7FFFFFFF; r.nbr_tag = 8'hFF;
    neighbor_q.push_back(r);
    r = '0; r.nbr_tag = 8'hFF; neighbor_q.push_back(r);
    r.last_neighbor = 1; neighbor_q.push_back(r);
    settle();

    random_sets(70);
    settle();
    write_reg(vesa_pkg::CFG_OWN_ID, 24'd5);
    write_reg(vesa_pkg::CFG_ACT_RANGE, 24'd256);
    write_reg(vesa_pkg::CFG_GW_FLOOR, 24'd0);
    random_sets(50);
    settle();
    write_reg(vesa_pkg::CFG_OWN_ID, 24'd77);
    write_reg(vesa_pkg::CFG_ACT_RANGE, 24'd2560);
    write_reg(vesa_pkg::CFG_GW_FLOOR, 24'd16384);
    long_hold_go = 1;
    random_sets(60);
    settle();
    write_reg(vesa_pkg::CFG_OWN_ID, 24'd200);
    write_reg(vesa_pkg::CFG_ACT_RANGE, 24'd2559);
    write_reg(vesa_pkg::CFG_GW_FLOOR, 24'd12000);
    random_sets(50);
    settle();
    write_reg(vesa_pkg::CFG_OWN_ID, 24'd255);
    write_reg(vesa_pkg::CFG_ACT_RANGE, 24'd16777215);
    write_reg(vesa_pkg::CFG_GW_FLOOR, 24'd1);
    random_sets(60);
    settle();
    write_reg(vesa_pkg::CFG_OWN_ID, 24'd130);
    write_reg(vesa_pkg::CFG_ACT_RANGE, 24'd7000);
    write_reg(vesa_pkg::CFG_GW_FLOOR, 24'd9000);
    random_sets(140);
    settle();

    $display("covered %0d neighbor requests and %0d set verdicts over six register settings",
             n_req, n_verdicts);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
